### hw/rtl/bdu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdu_pkg: shared types and constants for the bridge deal unranker
// Payload structs, divider request/response, and fixed deal constants.
// ----------------------------------------------------------------------------
package bdu_pkg;

  // Width of the running count and the deal number
  localparam int unsigned KW         = 96;
  localparam int unsigned CARD_COUNT = 52;
  localparam int unsigned HAND_SIZE  = 13;
  localparam int unsigned CW         = 6;   // card number / remainder width
  localparam int unsigned SW         = 4;   // seats-left width
  localparam int unsigned HANDS      = 4;

  // Number of distinct deals: 52! / (13!)^4
  localparam logic [KW-1:0] DEAL_TOTAL = 96'hAD55E315_634DDA65_8BF49200;

  // Serial divider: quotient bits resolved per cycle
  localparam int unsigned DIV_DIGIT = 8;
  localparam int unsigned DIV_STEPS = KW / DIV_DIGIT;

  typedef struct packed {
    logic [31:0] deal_index_high;
    logic [63:0] deal_index_low;
  } bdu_in_t;

  typedef struct packed {
    logic [51:0] north_hand;
    logic [51:0] east_hand;
    logic [51:0] south_hand;
    logic [51:0] west_hand;
    logic        index_valid;
  } bdu_out_t;

  typedef struct packed {
    logic          start;
    logic [KW-1:0] dividend;
    logic [CW-1:0] divisor;
  } bdu_div_req_t;

  typedef struct packed {
    logic          done;
    logic [KW-1:0] quot;
    logic [CW-1:0] rem;
  } bdu_div_rsp_t;

endpackage

### hw/rtl/bdu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdu_div: serial divider of the running count by the card number
// Restoring division, DIV_DIGIT quotient bits per cycle, done pulse at end.
// ----------------------------------------------------------------------------
module bdu_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bdu_pkg::bdu_div_req_t req,
  output bdu_pkg::bdu_div_rsp_t rsp
);
  import bdu_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [KW-1:0]    rq_r;     // dividend bits shift out the top, quotient in
  logic [KW-1:0]    rq_nxt;
  logic [CW-1:0]    rem_r;
  logic [CW-1:0]    rem_nxt;
  logic [CW-1:0]    div_r;
  logic [CW:0]      trial;

  // One digit of restoring division
  always_comb begin
    rq_nxt  = rq_r;
    rem_nxt = rem_r;
    trial   = '0;
    for (int i = 0; i < DIV_DIGIT; i++) begin
      trial  = {rem_nxt, rq_nxt[KW-1]};
      rq_nxt = {rq_nxt[KW-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        trial     = trial - {1'b0, div_r};
        rq_nxt[0] = 1'b1;
      end
      rem_nxt = trial[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_LAST);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rq_r   <= req.dividend;
        rem_r  <= '0;
        div_r  <= req.divisor;
      end else if (busy_r) begin
        rq_r  <= rq_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = rq_r;
  assign rsp.rem  = rem_r;

endmodule

### hw/rtl/bridge_deal_unrank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bridge_deal_unrank: deal number to four 13-card hands
// Unranks the multinomial of dealing 52 cards into four hands of 13.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries a 96-bit deal number.
//   Result channel (out_valid/out_ready/out_data) carries four 52-bit card
//   masks and index_valid. One result transfer per input transfer.
//   A deal number at or above the deal count gives all-zero hands and
//   index_valid low, going straight to ST_FIN with no card steps.
//   Per deal: 52 card steps. Each step divides the running count by the card
//   number on the serial divider (digits of 8 quotient bits, plus start and
//   hand-off), then for each hand tried, 1 to 4 hands, works out the share
//   and then compares/subtracts; the divider sets the bulk of the time.
//   One deal is in flight at a time; in_ready is high only when idle.
//   A finished result sits in the output register; the block takes the next
//   deal while that result waits, and holds a new result until the old one
//   is taken. Reset clears the sequencer and drops any pending result.
// ----------------------------------------------------------------------------
module bridge_deal_unrank (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bdu_pkg::bdu_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bdu_pkg::bdu_out_t out_data
);
  import bdu_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVS,
    ST_DIVW,
    ST_SHARE,
    ST_CMP,
    ST_FIN
  } state_t;

  localparam logic [1:0]    HAND_WEST = 2'd3;
  localparam logic [CW-1:0] CARD_LAST = CW'(1);

  state_t              state_r;
  logic [KW-1:0]       idx_r;
  logic [KW-1:0]       k_r;
  logic [KW-1:0]       q_r;
  logic [CW-1:0]       r_r;
  logic [KW-1:0]       share_r;
  logic [KW-1:0]       share_nxt;
  logic [CW-1:0]       card_r;
  logic [CW-1:0]       card_bit;
  logic [1:0]          hand_r;
  logic [SW-1:0]       seats_r [HANDS];
  logic [SW-1:0]       seat_sel;
  logic [HANDS-1:0][51:0] hands_r;
  logic                ok_r;
  logic                out_valid_r;
  bdu_out_t            out_data_r;
  logic [KW-1:0]       idx_in;
  logic [KW+SW-1:0]    prod;
  logic [9:0]          small_num;
  logic [SW-1:0]       small_q;
  logic                take_card;
  bdu_div_req_t        div_req;
  bdu_div_rsp_t        div_rsp;

  // floor(num / den) where the quotient is known to fit in SW bits
  function automatic logic [SW-1:0] small_quot(input logic [9:0] num,
                                               input logic [CW-1:0] den);
    logic [9:0]    rem;
    logic [9:0]    dsh;
    logic [SW-1:0] q;
    rem = num;
    q   = '0;
    for (int i = SW - 1; i >= 0; i--) begin
      dsh = {4'b0, den} << i;
      if (rem >= dsh) begin
        rem  = rem - dsh;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  bdu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign div_req.start    = (state_r == ST_DIVS);
  assign div_req.dividend = k_r;
  assign div_req.divisor  = card_r;

  assign idx_in   = {in_data.deal_index_high, in_data.deal_index_low};
  assign seat_sel = seats_r[hand_r];
  assign card_bit = card_r - 1'b1;

  // Share of the current hand: K*n/C = q*n + floor(r*n/C), with K = q*C + r
  always_comb begin
    prod = '0;
    for (int i = 0; i < SW; i++) begin
      if (seat_sel[i]) begin
        prod = prod + ((KW + SW)'(q_r) << i);
      end
    end
    small_num = 10'(r_r) * 10'(seat_sel);
    small_q   = small_quot(small_num, card_r);
    share_nxt = prod[KW-1:0] + KW'(small_q);
  end

  // West takes the card without a compare
  assign take_card = (hand_r == HAND_WEST) || (idx_r < share_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // Drop a taken result; in ST_FIN the reload below decides valid
      if (out_valid_r && out_ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            idx_r   <= idx_in;
            k_r     <= DEAL_TOTAL;
            card_r  <= CW'(CARD_COUNT);
            hands_r <= '0;
            for (int h = 0; h < HANDS; h++) begin
              seats_r[h] <= SW'(HAND_SIZE);
            end
            if (idx_in >= DEAL_TOTAL) begin
              ok_r    <= 1'b0;
              state_r <= ST_FIN;
            end else begin
              ok_r    <= 1'b1;
              state_r <= ST_DIVS;
            end
          end
        end
        ST_DIVS: begin
          state_r <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_rsp.done) begin
            q_r     <= div_rsp.quot;
            r_r     <= div_rsp.rem;
            hand_r  <= '0;
            state_r <= ST_SHARE;
          end
        end
        ST_SHARE: begin
          share_r <= share_nxt;
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          if (take_card) begin
            // Deal the card, shrink the count to this hand's share
            hands_r[hand_r][card_bit] <= 1'b1;
            if (seat_sel != '0) begin
              seats_r[hand_r] <= seat_sel - 1'b1;
            end
            k_r <= share_r;
            if (card_r == CARD_LAST) begin
              state_r <= ST_FIN;
            end else begin
              card_r  <= card_r - 1'b1;
              state_r <= ST_DIVS;
            end
          end else begin
            // Pass over this hand
            idx_r   <= idx_r - share_r;
            hand_r  <= hand_r + 1'b1;
            state_r <= ST_SHARE;
          end
        end
        ST_FIN: begin
          // Hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_data_r.north_hand  <= hands_r[0];
            out_data_r.east_hand   <= hands_r[1];
            out_data_r.south_hand  <= hands_r[2];
            out_data_r.west_hand   <= hands_r[3];
            out_data_r.index_valid <= ok_r;
            out_valid_r            <= 1'b1;
            state_r                <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hw/rtl/bdu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdu_checker: port-level checks for the bridge deal unranker
// Watches both channels; bound to the top level below.
// ----------------------------------------------------------------------------
module bdu_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input bdu_pkg::bdu_out_t out_data
);
  import bdu_pkg::*;

  localparam logic [51:0] ALL_CARDS = {52{1'b1}};

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An accepted deal keeps the block busy in the next cycle
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  // An out-of-range deal number gives empty hands
  a_invalid_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.index_valid |->
      (out_data.north_hand == '0) && (out_data.east_hand == '0) &&
      (out_data.south_hand == '0) && (out_data.west_hand == '0))
    else $error("out-of-range deal with cards dealt");

  // A valid deal splits all 52 cards into four disjoint hands
  a_valid_partition: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.index_valid |->
      ((out_data.north_hand | out_data.east_hand |
        out_data.south_hand | out_data.west_hand) == ALL_CARDS) &&
      ((out_data.north_hand & out_data.east_hand) == '0) &&
      ((out_data.south_hand & out_data.west_hand) == '0) &&
      (((out_data.north_hand | out_data.east_hand) &
        (out_data.south_hand | out_data.west_hand)) == '0))
    else $error("hands do not partition the deck");

  // North, East and South of a valid deal each hold thirteen cards
  a_valid_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.index_valid |->
      ($countones(out_data.north_hand) == HAND_SIZE) &&
      ($countones(out_data.east_hand) == HAND_SIZE) &&
      ($countones(out_data.south_hand) == HAND_SIZE))
    else $error("hand size is not thirteen");

endmodule

bind bridge_deal_unrank bdu_checker u_bdu_checker (.*);

### bench/bridge_deal_unrank_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bridge_deal_unrank_tb: self-checking bench for the bridge deal unranker
// Drives deal numbers over the input handshake and checks each set of four
// hands against a local unranking model or typed-in hands, first from a table
// of directed deals, then from random deals, with random idling on both channels.
// ----------------------------------------------------------------------------
module bridge_deal_unrank_tb;
  import bdu_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 12;
  localparam int TOTAL_DEALS = 500;
  // Give the tail the time of the slowest deal and more.
  localparam int DRAIN_CYCLES = 1500;
  // Run limit in ns, well beyond what 500 deals at the slowest rate take.
  localparam longint unsigned RUN_LIMIT_NS = 64'd36_000_000;

  localparam logic [31:0] TOTAL_HIGH = DEAL_TOTAL[95:64];
  localparam logic [63:0] TOTAL_LOW  = DEAL_TOTAL[63:0];

  // Thirteen-card blocks: highest cards, next, next, lowest
  localparam logic [51:0] TOP_BLOCK    = 52'hFFF8000000000;
  localparam logic [51:0] SECOND_BLOCK = 52'h0007FFC000000;
  localparam logic [51:0] THIRD_BLOCK  = 52'h0000003FFE000;
  localparam logic [51:0] LOW_BLOCK    = 52'h0000000001FFF;

  // Deal 0 hands the cards out in seat order; the last deal fills West first
  // and then works back toward North. Out of range gives nothing.
  localparam bdu_out_t FIRST_DEAL =
    {TOP_BLOCK, SECOND_BLOCK, THIRD_BLOCK, LOW_BLOCK, 1'b1};
  localparam bdu_out_t LAST_DEAL =
    {LOW_BLOCK, THIRD_BLOCK, SECOND_BLOCK, TOP_BLOCK, 1'b1};
  localparam bdu_out_t NO_DEAL = '0;

  typedef enum int {NORTH = 0, EAST = 1, SOUTH = 2, WEST = 3} seat_e;

  typedef struct {
    bdu_in_t  deal;
    bit       typed;   // use the typed-in hands instead of the model
    bdu_out_t want;
  } deal_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  bdu_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  bdu_out_t out_data;

  bdu_out_t  pending_hands[$];
  deal_row_t deal_table[$];
  int        deals_sent = 0;
  int        error_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  bridge_deal_unrank DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // Unrank one deal number into four hands. The running count starts at the
  // deal total; each card goes to the first seat whose share of the count
  // covers what is left of the index, subtracting the shares passed over.
  function automatic bdu_out_t unrank_deal(input bdu_in_t deal);
    logic [127:0] rest;
    logic [127:0] count;
    logic [127:0] share;
    logic [5:0]   card;
    logic [3:0]   seats[HANDS];
    logic [51:0]  hands[HANDS];
    int           taker;
    int           h;
    bdu_out_t     r;
    rest  = {32'd0, deal.deal_index_high, deal.deal_index_low};
    count = {32'd0, DEAL_TOTAL};
    r     = NO_DEAL;
    if (rest >= count) return r;
    for (h = 0; h < HANDS; h++) begin
      seats[h] = 4'(HAND_SIZE);
      hands[h] = '0;
    end
    for (card = 6'(CARD_COUNT); card > 0; card--) begin
      taker = WEST;
      for (h = NORTH; h < WEST; h++) begin
        if (taker == WEST) begin
          share = count * seats[h] / card;
          // A full seat has a zero share: never takes, subtracts nothing
          if (rest < share) taker = h;
          else rest = rest - share;
        end
      end
      share = count * seats[taker] / card;
      hands[taker][card - 1'b1] = 1'b1;
      if (seats[taker] != 0) seats[taker]--;
      count = share;
    end
    r.north_hand  = hands[NORTH];
    r.east_hand   = hands[EAST];
    r.south_hand  = hands[SOUTH];
    r.west_hand   = hands[WEST];
    r.index_valid = 1'b1;
    return r;
  endfunction

  function automatic deal_row_t row(input logic [31:0] high, input logic [63:0] low,
                                    input bit typed, input bdu_out_t want);
    deal_row_t t;
    t.deal.deal_index_high = high;
    t.deal.deal_index_low  = low;
    t.typed = typed;
    t.want  = want;
    return t;
  endfunction

  // Mostly legal deal numbers, some right at the top of the range, some past it.
  function automatic bdu_in_t random_deal();
    bdu_in_t d;
    int      pick;
    pick = $urandom_range(99);
    d.deal_index_low = {$urandom, $urandom};
    if (pick < 75) begin
      d.deal_index_high = $urandom_range(TOTAL_HIGH - 1, 0);
    end else if (pick < 85) begin
      d.deal_index_high = TOTAL_HIGH;
      d.deal_index_low  = d.deal_index_low % TOTAL_LOW;
    end else if (pick < 90) begin
      // Same top word, low word at or past the total: out of range
      d.deal_index_high = TOTAL_HIGH;
      if (d.deal_index_low < TOTAL_LOW) d.deal_index_low[63] = 1'b1;
    end else begin
      d.deal_index_high = $urandom_range(32'hFFFF_FFFF, TOTAL_HIGH + 1);
    end
    return d;
  endfunction

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what);
    $display("%0t ns: MISMATCH %s", $time, what);
    error_count++;
  endtask

  // Set the idle mix by progress: receiver-heavy, then sender-heavy, then none.
  task automatic pick_idling();
    if (deals_sent < TOTAL_DEALS / 3) begin
      send_idle_pct = 26;
      recv_idle_pct = 57;
    end else if (deals_sent < 2 * TOTAL_DEALS / 3) begin
      send_idle_pct = 57;
      recv_idle_pct = 26;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // Offer one deal and hold it until the transfer. Valid stays high into the
  // next deal unless a gap is rolled, so it is never dropped and raised in
  // one step.
  task automatic offer_deal(input bdu_in_t deal, input bit typed, input bdu_out_t want);
    pick_idling();
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= deal;
    do @(posedge clk); while (!in_ready);
    pending_hands.push_back(typed ? want : unrank_deal(deal));
    deals_sent++;
  endtask

  // Result side: check each transfer against the oldest expected hands, then
  // roll the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_hands.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_data));
        end else begin
          bdu_out_t want;
          want = pending_hands.pop_front();
          if (out_data.north_hand !== want.north_hand)
            report_mismatch($sformatf("north_hand got %h want %h",
                                      out_data.north_hand, want.north_hand));
          if (out_data.east_hand !== want.east_hand)
            report_mismatch($sformatf("east_hand got %h want %h",
                                      out_data.east_hand, want.east_hand));
          if (out_data.south_hand !== want.south_hand)
            report_mismatch($sformatf("south_hand got %h want %h",
                                      out_data.south_hand, want.south_hand));
          if (out_data.west_hand !== want.west_hand)
            report_mismatch($sformatf("west_hand got %h want %h",
                                      out_data.west_hand, want.west_hand));
          if (out_data.index_valid !== want.index_valid)
            report_mismatch($sformatf("index_valid got %b want %b",
                                      out_data.index_valid, want.index_valid));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    // Directed deals: both ends of the range, the first values past it, and
    // bit patterns across both words of the index.
    deal_table.push_back(row(32'h0, 64'h0, 1'b1, FIRST_DEAL));
    deal_table.push_back(row(TOTAL_HIGH, TOTAL_LOW - 1, 1'b1, LAST_DEAL));
    deal_table.push_back(row(TOTAL_HIGH, TOTAL_LOW, 1'b1, NO_DEAL));
    deal_table.push_back(row(TOTAL_HIGH, TOTAL_LOW + 1, 1'b1, NO_DEAL));
    deal_table.push_back(row(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, NO_DEAL));
    deal_table.push_back(row(32'hFFFF_FFFF, 64'h0, 1'b1, NO_DEAL));
    deal_table.push_back(row(TOTAL_HIGH + 1, 64'h0, 1'b1, NO_DEAL));
    deal_table.push_back(row(32'h0, 64'h1, 1'b0, NO_DEAL));
    deal_table.push_back(row(32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_DEAL));
    deal_table.push_back(row(32'h1, 64'h0, 1'b0, NO_DEAL));
    deal_table.push_back(row(TOTAL_HIGH, 64'h0, 1'b0, NO_DEAL));
    deal_table.push_back(row(TOTAL_HIGH, TOTAL_LOW - 2, 1'b0, NO_DEAL));
    deal_table.push_back(row(TOTAL_HIGH - 1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_DEAL));
    deal_table.push_back(row(32'h5555_5555, 64'h5555_5555_5555_5555, 1'b0, NO_DEAL));
    deal_table.push_back(row(32'h2AAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NO_DEAL));
    deal_table.push_back(row(32'h56AA_F18A, 64'h8000_0000_0000_0000, 1'b0, NO_DEAL));
    deal_table.push_back(row(32'h8000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, NO_DEAL));

    // Hold reset, release it at an edge
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (deal_table[i])
      offer_deal(deal_table[i].deal, deal_table[i].typed, deal_table[i].want);
    while (deals_sent < TOTAL_DEALS)
      offer_deal(random_deal(), 1'b0, NO_DEAL);
    in_valid <= 1'b0;

    // Drain: wait for every expected result, then watch for strays
    while (pending_hands.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run
  initial begin
    #(RUN_LIMIT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule
